### sv/pctf_pkg.sv
// ----------------------------------------------------------------------------
// pctf_pkg
// Shared types and constants of the pulse-count temperature filter.
// ----------------------------------------------------------------------------
package pctf_pkg;

  localparam int unsigned COUNT_BITS_DEF  = 16;
  localparam int unsigned EXTRA_FRAC_DEF  = 8;

  localparam int unsigned IN_FIELD_W = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned TEMP_W     = 25;
  localparam int unsigned WEIGHT_W   = 16;

  localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd100;
  localparam logic [CFG_W-1:0] MIN_CNT_RST = 16'd10;
  localparam logic [CFG_W-1:0] WEIGHT_RST  = 16'd3277;

  // count offset for 0 degC, sample scale (1/16 degC per count -> 1/4096 units)
  localparam int unsigned COUNT_OFFSET = 800;
  localparam int unsigned SAMPLE_SHIFT = 8;
  localparam int unsigned SAMPLE_MAX   = 16777215;
  localparam int unsigned DIFF_SAT     = 65535;
  localparam int unsigned ROUND_HALF   = 32768;
  localparam int unsigned WEIGHT_FRAC  = 16;

  typedef enum logic [1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_MIN_COUNT = 2'd1,
    CFG_WEIGHT    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic clear;
    logic sample_en;
    logic raised;
    logic fault_active;
  } pctf_ctrl_t;

endpackage

### sv/pctf_detect.sv
// ----------------------------------------------------------------------------
// pctf_detect
// Stable-count detection, no-pulse tick counter and fault latch.
// ----------------------------------------------------------------------------
module pctf_detect
  import pctf_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic [CFG_W-1:0]      timeout_i,
  input  logic [CFG_W-1:0]      min_count_i,
  output pctf_ctrl_t            ctrl_o
);

  localparam int unsigned MW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic [COUNT_BITS-1:0] last_q, last_d;
  logic [CFG_W-1:0]      zero_q, zero_d;
  logic                  fault_q, fault_d;
  logic                  is_zero;
  logic                  stable;
  logic                  above_min;
  logic                  raised;

  assign is_zero   = (count_i == '0);
  assign stable    = !is_zero && (last_q == count_i);
  assign above_min = MW'(count_i) > MW'(min_count_i);

  always_comb begin
    zero_d  = zero_q;
    fault_d = fault_q;
    raised  = 1'b0;
    if (is_zero) begin
      if (zero_q < timeout_i) begin
        zero_d = zero_q + CFG_W'(1);
      end
      if ((zero_d >= timeout_i) && !fault_q) begin
        fault_d = 1'b1;
        raised  = 1'b1;
      end
    end else begin
      zero_d  = '0;
      fault_d = 1'b0;
    end
  end

  assign last_d = count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      zero_q  <= '0;
      fault_q <= 1'b0;
    end else if (en_i) begin
      last_q  <= last_d;
      zero_q  <= zero_d;
      fault_q <= fault_d;
    end
  end

  assign ctrl_o.clear        = stable;
  assign ctrl_o.sample_en    = stable && above_min;
  assign ctrl_o.raised       = raised;
  assign ctrl_o.fault_active = fault_d;

endmodule

### sv/pctf_ema.sv
// ----------------------------------------------------------------------------
// pctf_ema
// Count-to-temperature conversion and exponential filter with rounding.
// ----------------------------------------------------------------------------
module pctf_ema
  import pctf_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned EXTRA_FRACTION_BITS = EXTRA_FRAC_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     sample_en_i,
  input  logic [COUNT_BITS-1:0]    count_i,
  input  logic [WEIGHT_W-1:0]      weight_i,
  output logic signed [TEMP_W-1:0] temp_o
);

  localparam int unsigned DW   = ((COUNT_BITS > 17) ? COUNT_BITS : 17) + 2;
  localparam int unsigned FW   = TEMP_W + 1 + EXTRA_FRACTION_BITS;
  localparam int unsigned PW   = FW + 1 + WEIGHT_W + 1;
  localparam int unsigned HALF = (EXTRA_FRACTION_BITS > 0) ?
                                 (1 << (EXTRA_FRACTION_BITS - 1)) : 0;

  logic signed [FW-1:0]     filt_q, filt_d;
  logic                     have_q, have_d;
  logic signed [DW-1:0]     diff;
  logic signed [TEMP_W-1:0] samp_base;
  logic signed [FW-1:0]     samp;
  logic signed [FW:0]       delta;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     step;
  logic signed [FW-1:0]     rounded;

  assign diff = $signed({1'b0, (DW-1)'(count_i)}) - $signed(DW'(COUNT_OFFSET));

  always_comb begin
    if (diff > $signed(DW'(DIFF_SAT))) begin
      samp_base = TEMP_W'(SAMPLE_MAX);
    end else begin
      samp_base = $signed({diff[TEMP_W-SAMPLE_SHIFT-1:0], SAMPLE_SHIFT'(0)});
    end
  end

  assign samp  = FW'(samp_base) <<< EXTRA_FRACTION_BITS;
  assign delta = (FW+1)'(samp) - (FW+1)'(filt_q);
  assign prod  = PW'(delta) * $signed({1'b0, weight_i});
  assign step  = (prod + $signed(PW'(ROUND_HALF))) >>> WEIGHT_FRAC;

  always_comb begin
    filt_d = filt_q;
    have_d = have_q;
    if (sample_en_i) begin
      have_d = 1'b1;
      if (!have_q) begin
        filt_d = samp;
      end else begin
        filt_d = filt_q + step[FW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
      have_q <= 1'b0;
    end else if (en_i) begin
      filt_q <= filt_d;
      have_q <= have_d;
    end
  end

  assign rounded = (filt_d + $signed(FW'(HALF))) >>> EXTRA_FRACTION_BITS;
  assign temp_o  = rounded[TEMP_W-1:0];

endmodule

### sv/pulse_count_temperature_filter.sv
// ----------------------------------------------------------------------------
// pulse_count_temperature_filter
// Poll-tick pulse counter monitor with no-pulse fault and filtered temperature.
// ----------------------------------------------------------------------------
// One request per poll tick carries the sampled pulse count; each request
// yields exactly one result. The block takes a request every cycle unless
// stalled: a request waits in the input register, the detect and filter
// logic updates the state as it advances, and the result lands in the
// output register, so throughput is one request per cycle whenever the
// output side keeps up. Temperature is two's complement in 1/4096 degC and
// repeats the last filtered value on ticks without a new one (zero before the
// first). Configuration writes take effect on the next processed request.
module pulse_count_temperature_filter
  import pctf_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned EXTRA_FRACTION_BITS = EXTRA_FRAC_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [15:0] pulse_count
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [0] clear_counter, [25:1] temperature,
                                            // [26] fault_raised, [27] fault_active
  output logic              m_axis_tuser,   // [0] temp_valid
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  logic [CFG_W-1:0]      timeout_q, min_cnt_q, weight_q;
  logic                  in_valid_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  advance;
  pctf_ctrl_t            ctrl;
  logic signed [TEMP_W-1:0] temp;

  logic                     out_valid_q;
  logic                     o_clear_q, o_tvalid_q, o_raised_q, o_active_q;
  logic signed [TEMP_W-1:0] o_temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      min_cnt_q <= MIN_CNT_RST;
      weight_q  <= WEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMEOUT:   timeout_q <= cfg_wdata_i;
        CFG_MIN_COUNT: min_cnt_q <= cfg_wdata_i;
        CFG_WEIGHT:    weight_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      count_q <= COUNT_BITS'(s_axis_tdata);
    end
  end

  pctf_detect #(
    .COUNT_BITS (COUNT_BITS)
  ) u_detect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .count_i     (count_q),
    .timeout_i   (timeout_q),
    .min_count_i (min_cnt_q),
    .ctrl_o      (ctrl)
  );

  pctf_ema #(
    .COUNT_BITS          (COUNT_BITS),
    .EXTRA_FRACTION_BITS (EXTRA_FRACTION_BITS)
  ) u_ema (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .sample_en_i (ctrl.sample_en),
    .count_i     (count_q),
    .weight_i    (weight_q),
    .temp_o      (temp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      o_clear_q  <= ctrl.clear;
      o_tvalid_q <= ctrl.sample_en;
      o_raised_q <= ctrl.raised;
      o_active_q <= ctrl.fault_active;
      o_temp_q   <= temp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = o_tvalid_q;
  assign m_axis_tdata  = {4'd0, o_active_q, o_raised_q, o_temp_q, o_clear_q};

  a_raise_implies_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_raised_q |-> o_active_q)
    else $error("fault raised without latched fault");

  a_temp_needs_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_tvalid_q |-> o_clear_q)
    else $error("temperature published on an unstable count");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(count_q))
    else $error("stalled request lost");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed request produced no result");

endmodule
